/* hdl/sap_pkg.sv */
// ----------------------------------------------------------------------------
// sap_pkg
// shared types and constants of the shelf atlas packer
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int W_W      = 12;   // request width field
    localparam int H_W      = 12;   // request height field
    localparam int H10_W    = 16;   // ten times the height
    localparam int SH_W     = 13;   // shelf height and cursor
    localparam int TOP_W    = 12;   // shelf top
    localparam int SIDE_W   = 17;   // image side, holds up to 65536
    localparam int AS_W     = 13;   // reported image side

    // ratio window: 10*h >= 7*shelf_height
    localparam int RATIO_NUM = 7;
    localparam int RATIO_DEN = 10;

    // h/10 as (h*3277) >> 15, exact for 12-bit h
    localparam int DIV10_MUL   = 3277;
    localparam int DIV10_SHIFT = 15;

    localparam int RESERVED_ROWS = 2;

    localparam logic [1:0] STATUS_PLACED = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_SIZE   = 2'd2;

    typedef struct packed {
        logic [W_W-1:0]   w;
        logic [H_W-1:0]   h;
        logic [H10_W-1:0] h10;
        logic [SH_W-1:0]  rh;    // height of a new shelf
    } sap_item_t;

    typedef struct packed {
        logic [SH_W-1:0]  cursor;
        logic [TOP_W-1:0] top;
        logic [SH_W-1:0]  height;
    } sap_shelf_t;

    typedef struct packed {
        logic [11:0]     place_x;
        logic [11:0]     place_y;
        logic [AS_W-1:0] atlas_width;
        logic [AS_W-1:0] atlas_height;
        logic [1:0]      status;
    } sap_result_t;

endpackage

/* hdl/sap_front.sv */
// ----------------------------------------------------------------------------
// sap_front
// input stage: takes requests and derives the ratio bound and new shelf height
// ----------------------------------------------------------------------------
module sap_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,
    output logic                push,
    input  logic                push_ready,
    output sap_pkg::sap_item_t  push_item
);
    import sap_pkg::*;

    logic               st_valid_reg;
    sap_item_t          st_item_reg;
    logic [W_W-1:0]     in_w;
    logic [H_W-1:0]     in_h;
    logic [23:0]        prod;
    logic [SH_W-1:0]    tenth;
    sap_item_t          item_next;

    assign in_w = s_tdata[11:0];
    assign in_h = s_tdata[23:12];

    always_comb begin
        prod           = {12'd0, in_h} * 24'(DIV10_MUL);
        tenth          = SH_W'(prod >> DIV10_SHIFT);
        item_next.w    = in_w;
        item_next.h    = in_h;
        item_next.h10  = H10_W'(in_h) * H10_W'(RATIO_DEN);
        item_next.rh   = SH_W'(in_h) + tenth;
    end

    assign s_tready  = !st_valid_reg || push_ready;
    assign push      = st_valid_reg;
    assign push_item = st_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            st_valid_reg <= 1'b1;
        end else if (push_ready) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            st_item_reg <= item_next;
        end
    end

endmodule

/* hdl/sap_queue.sv */
// ----------------------------------------------------------------------------
// sap_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module sap_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    output logic                push_ready,
    input  sap_pkg::sap_item_t  push_item,
    output logic                q_valid,
    input  logic                pop,
    output sap_pkg::sap_item_t  q_item
);
    import sap_pkg::*;

    sap_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_item     = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/sap_back.sv */
// ----------------------------------------------------------------------------
// sap_back
// shelf table scan, shelf opening with image growth, and result register
// ----------------------------------------------------------------------------
module sap_back #(
    parameter int MAX_SHELVES  = 32,
    parameter int INITIAL_SIDE = 128,
    parameter int MAXIMUM_SIDE = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  sap_pkg::sap_item_t    q_item,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sap_pkg::sap_result_t  m_result
);
    import sap_pkg::*;

    localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int CNT_W = $clog2(MAX_SHELVES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_GROW   = 3'd3;

    sap_shelf_t shelf_mem [MAX_SHELVES];
    sap_shelf_t rdata_reg;

    logic [2:0]         state_reg,     state_next;
    sap_item_t          item_reg,      item_next;
    logic [CNT_W-1:0]   scan_idx_reg,  scan_idx_next;
    logic               eval_reg,      eval_next;
    logic [IDX_W-1:0]   eval_idx_reg,  eval_idx_next;
    logic               found_reg,     found_next;
    logic [IDX_W-1:0]   pick_reg,      pick_next;
    sap_shelf_t         best_reg,      best_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [SH_W-1:0]    nfy_reg,       nfy_next;
    logic [SIDE_W-1:0]  side_w_reg,    side_w_next;
    logic [SIDE_W-1:0]  side_h_reg,    side_h_next;
    logic [SIDE_W-1:0]  grow_w_reg,    grow_w_next;
    logic [SIDE_W-1:0]  grow_h_reg,    grow_h_next;
    logic               out_valid_reg, out_valid_next;
    sap_result_t        out_reg,       out_next;

    logic               issue;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    sap_shelf_t         wr_data;
    logic               match;
    logic [SH_W:0]      fit_sum;
    logic [SH_W:0]      row_end;
    logic [SIDE_W:0]    dbl_w;
    logic [SIDE_W:0]    dbl_h;
    logic [H10_W-1:0]   low_bound;

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        scan_idx_next  = scan_idx_reg;
        eval_next      = 1'b0;
        eval_idx_next  = eval_idx_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        count_next     = count_reg;
        nfy_next       = nfy_reg;
        side_w_next    = side_w_reg;
        side_h_next    = side_h_reg;
        grow_w_next    = grow_w_reg;
        grow_h_next    = grow_h_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pick_reg;
        wr_data        = best_reg;

        issue   = (scan_idx_reg < count_reg);
        rd_addr = scan_idx_reg[IDX_W-1:0];

        // candidate test on the entry read last cycle
        fit_sum   = {1'b0, rdata_reg.cursor} + (SH_W+1)'(item_reg.w);
        low_bound = H10_W'(rdata_reg.height) * H10_W'(RATIO_NUM);
        match = (rdata_reg.height != '0)
             && (item_reg.h10 >= low_bound)
             && (SH_W'(item_reg.h) <= rdata_reg.height)
             && (!found_reg || rdata_reg.height <= best_reg.height)
             && (SIDE_W'(fit_sum) <= side_w_reg);

        row_end = {1'b0, nfy_reg} + {1'b0, item_reg.rh};
        dbl_w   = {grow_w_reg, 1'b0};
        dbl_h   = {grow_h_reg, 1'b0};

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    pop           = 1'b1;
                    item_next     = q_item;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one read issued and one entry judged per cycle
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    eval_next     = 1'b1;
                    eval_idx_next = scan_idx_reg[IDX_W-1:0];
                end
                if (eval_reg && match) begin
                    found_next = 1'b1;
                    pick_next  = eval_idx_reg;
                    best_next  = rdata_reg;
                end
                if (!issue && !eval_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (found_reg) begin
                    wr_en          = 1'b1;
                    wr_addr        = pick_reg;
                    wr_data        = best_reg;
                    wr_data.cursor = SH_W'({1'b0, best_reg.cursor}
                                         + (SH_W+1)'(item_reg.w));
                    out_next.place_x      = best_reg.cursor[11:0];
                    out_next.place_y      = best_reg.top;
                    out_next.atlas_width  = side_w_reg[AS_W-1:0];
                    out_next.atlas_height = side_h_reg[AS_W-1:0];
                    out_next.status       = STATUS_PLACED;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end else if (count_reg == CNT_W'(MAX_SHELVES)) begin
                    out_next.place_x      = '0;
                    out_next.place_y      = '0;
                    out_next.atlas_width  = side_w_reg[AS_W-1:0];
                    out_next.atlas_height = side_h_reg[AS_W-1:0];
                    out_next.status       = STATUS_FULL;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end else begin
                    grow_w_next = side_w_reg;
                    grow_h_next = side_h_reg;
                    state_next  = ST_GROW;
                end
            end
            ST_GROW: begin
                // one doubling per cycle until the new row fits or the size limit is reached
                if (SIDE_W'(row_end) >= grow_h_reg) begin
                    if (dbl_h > (SIDE_W+1)'(MAXIMUM_SIDE)
                            || dbl_w > (SIDE_W+1)'(MAXIMUM_SIDE)
                            || grow_h_reg == '0) begin
                        out_next.place_x      = '0;
                        out_next.place_y      = '0;
                        out_next.atlas_width  = side_w_reg[AS_W-1:0];
                        out_next.atlas_height = side_h_reg[AS_W-1:0];
                        out_next.status       = STATUS_SIZE;
                        out_valid_next        = 1'b1;
                        state_next            = ST_IDLE;
                    end else begin
                        grow_w_next = dbl_w[SIDE_W-1:0];
                        grow_h_next = dbl_h[SIDE_W-1:0];
                    end
                end else begin
                    wr_en          = 1'b1;
                    wr_addr        = count_reg[IDX_W-1:0];
                    wr_data.cursor = SH_W'(item_reg.w);
                    wr_data.top    = nfy_reg[TOP_W-1:0];
                    wr_data.height = item_reg.rh;
                    side_w_next    = grow_w_reg;
                    side_h_next    = grow_h_reg;
                    count_next     = count_reg + CNT_W'(1);
                    nfy_next       = row_end[SH_W-1:0];
                    out_next.place_x      = '0;
                    out_next.place_y      = nfy_reg[TOP_W-1:0];
                    out_next.atlas_width  = grow_w_reg[AS_W-1:0];
                    out_next.atlas_height = grow_h_reg[AS_W-1:0];
                    out_next.status       = STATUS_PLACED;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            eval_reg      <= 1'b0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            nfy_reg       <= SH_W'(RESERVED_ROWS);
            side_w_reg    <= SIDE_W'(INITIAL_SIDE);
            side_h_reg    <= SIDE_W'(INITIAL_SIDE);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            eval_reg      <= eval_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            nfy_reg       <= nfy_next;
            side_w_reg    <= side_w_next;
            side_h_reg    <= side_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        scan_idx_reg <= scan_idx_next;
        eval_idx_reg <= eval_idx_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        grow_w_reg   <= grow_w_next;
        grow_h_reg   <= grow_h_next;
        out_reg      <= out_next;
    end

    // shelf table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            shelf_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= shelf_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SHELVES))
        else $error("shelf count above table depth");

    a_sides_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        side_w_reg == side_h_reg)
        else $error("image sides diverged");

    a_side_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        side_h_reg <= SIDE_W'(MAXIMUM_SIDE))
        else $error("image side above limit");

    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && out_valid_next && out_next.status != STATUS_PLACED)
        |=> $stable(count_reg) && $stable(nfy_reg) && $stable(side_h_reg))
        else $error("error result changed allocator state");

    a_busy_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_GROW) |-> !out_valid_reg)
        else $error("work started while result pending");

endmodule

/* hdl/shelf_atlas_packer_core.sv */
// ----------------------------------------------------------------------------
// shelf_atlas_packer_core
// shelf allocator for a texture atlas: places rectangles on rows of an image
// ----------------------------------------------------------------------------
// flow: each request passes the front register and the queue; the back end then scans
//   the stored shelves, opens a new shelf and doubles the image where needed
// the back end scans one shelf per cycle and takes no new item from the queue until
//   the result of the last one has been taken
// reset: control state, shelf count, row cursor and image sides take their start
//   values; the shelf table is not cleared, only entries below the count are used
module shelf_atlas_packer_core #(
    parameter int MAX_SHELVES  = 32,
    parameter int INITIAL_SIDE = 128,
    parameter int MAXIMUM_SIDE = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // req_width[11:0], req_height[23:12]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // place_x[11:0], place_y[23:12],
                                   // atlas_width[36:24], atlas_height[49:37], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import sap_pkg::*;

    // front to queue
    logic        push;
    logic        push_ready;
    sap_item_t   push_item;

    // queue to back
    logic        q_valid;
    logic        pop;
    sap_item_t   q_item;

    sap_result_t result;

    // front: takes requests, computes 10*h and the new shelf height
    sap_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // short queue so the front keeps taking items while the back scans
    sap_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .q_valid    (q_valid),
        .pop        (pop),
        .q_item     (q_item)
    );

    // back: best-fit scan over the shelf table, shelf opening, result register
    sap_back #(
        .MAX_SHELVES  (MAX_SHELVES),
        .INITIAL_SIDE (INITIAL_SIDE),
        .MAXIMUM_SIDE (MAXIMUM_SIDE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // result packing, lowest field first
    assign m_tdata = {6'd0, result.atlas_height, result.atlas_width,
                      result.place_y, result.place_x};
    assign m_tuser = result.status;

endmodule

/* test/tb_shelf_atlas_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shelf_atlas_packer_core
// self-checking bench for the shelf atlas packer: a directed table (reset
// state, field extremes, zero sizes, ties, doubling, size limit) followed by
// random requests under changing backpressure, every result compared with a
// shelf-table model kept in the bench
// ----------------------------------------------------------------------------
module tb_shelf_atlas_packer_core;
    import sap_pkg::*;

    localparam int MAX_SHELVES  = 32;
    localparam int INITIAL_SIDE = 128;
    localparam int MAXIMUM_SIDE = 4096;

    localparam int RANDOM_ITEMS   = 1350;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving
    localparam int PRINT_CAP      = 40;

    // one row of the directed table; res is used only when typed is set
    typedef struct packed {
        logic [11:0] w;
        logic [11:0] h;
        logic        typed;
        sap_result_t res;
    } req_row_t;

    localparam int N_DIRECTED = 16;
    localparam req_row_t DIRECTED [N_DIRECTED] = '{
        // first request after reset: new shelf at the reserved rows
        '{12'd10,   12'd10,   1'b1, '{12'd0, 12'd2, 13'd128, 13'd128, STATUS_PLACED}},
        // both fields at their maximum: image cannot grow far enough
        '{12'd4095, 12'd4095, 1'b1, '{12'd0, 12'd0, 13'd128, 13'd128, STATUS_SIZE}},
        '{12'd0,    12'd0,    1'b0, '0},   // zero width and zero height
        '{12'd20,   12'd8,    1'b0, '0},   // fits the first shelf
        '{12'd120,  12'd10,   1'b0, '0},   // no width left, opens a shelf
        '{12'd4095, 12'd50,   1'b0, '0},   // new shelf wider than the image
        '{12'd5,    12'd100,  1'b0, '0},   // one doubling
        '{12'd5,    12'd9,    1'b0, '0},   // equal heights, later shelf wins
        '{12'd251,  12'd100,  1'b0, '0},   // shelf filled to the image width
        '{12'd0,    12'd100,  1'b0, '0},   // zero width on a full shelf
        '{12'd240,  12'd9,    1'b0, '0},   // opens a lower shelf
        '{12'd10,   12'd8,    1'b0, '0},   // lowest fitting shelf wins
        '{12'd3,    12'd1500, 1'b0, '0},   // several doublings at once
        '{12'd4095, 12'd1,    1'b0, '0},
        '{12'd0,    12'd4095, 1'b0, '0},   // size limit at a larger image
        '{12'd4095, 12'd0,    1'b0, '0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    // model copy of the shelf table and image
    logic [12:0] shf_cursor [MAX_SHELVES];
    logic [11:0] shf_top    [MAX_SHELVES];
    logic [12:0] shf_height [MAX_SHELVES];
    int unsigned shf_count  = 0;
    int unsigned row_y      = RESERVED_ROWS;
    int unsigned side_w     = INITIAL_SIDE;
    int unsigned side_h     = INITIAL_SIDE;

    sap_result_t placement_q [$];

    int unsigned snd_idle_pct    = 0;
    int unsigned rcv_idle_pct    = 0;
    int unsigned hold_ask_count  = 0;
    int unsigned hold_seen_count = 0;
    int unsigned hold_left       = 0;

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned sent_count     = 0;
    int unsigned placed_count   = 0;
    int unsigned full_count     = 0;
    int unsigned size_count     = 0;

    shelf_atlas_packer_core #(
        .MAX_SHELVES  (MAX_SHELVES),
        .INITIAL_SIDE (INITIAL_SIDE),
        .MAXIMUM_SIDE (MAXIMUM_SIDE)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // place one rectangle in the model, returning the result the block owes
    function automatic sap_result_t place_rect(input logic [11:0] w, input logic [11:0] h);
        sap_result_t r;
        int unsigned pick, best, rh, nw, nh, x;
        bit found;
        r = '0;
        pick = 0;
        best = 0;
        found = 1'b0;
        for (int i = 0; i < shf_count; i++) begin
            rh = 32'(shf_height[i]);
            // ratio window h/rh in [0.7, 1.0]; best means lowest, ties go late
            if (rh != 0 && 10 * h >= 7 * rh && h <= rh && !(found && rh > best)
                && shf_cursor[i] + w <= side_w) begin
                found = 1'b1;
                pick = i;
                best = rh;
            end
        end
        r.atlas_width  = side_w[12:0];
        r.atlas_height = side_h[12:0];
        if (!found) begin
            rh = h + h / 10;
            if (shf_count >= MAX_SHELVES) begin
                r.status = STATUS_FULL;
                return r;
            end
            nw = side_w;
            nh = side_h;
            while (row_y + rh >= nh) begin
                if (2 * nh > MAXIMUM_SIDE || 2 * nw > MAXIMUM_SIDE || nh == 0) begin
                    r.status = STATUS_SIZE;
                    return r;
                end
                nw = 2 * nw;
                nh = 2 * nh;
            end
            side_w = nw;
            side_h = nh;
            pick = shf_count;
            shf_cursor[pick] = '0;
            shf_top[pick]    = row_y[11:0];
            shf_height[pick] = rh[12:0];
            shf_count++;
            row_y = (row_y + rh) & 32'h1fff;
        end
        x = 32'(shf_cursor[pick]);
        r.place_x      = x[11:0];
        r.place_y      = shf_top[pick];
        r.atlas_width  = side_w[12:0];
        r.atlas_height = side_h[12:0];
        r.status       = STATUS_PLACED;
        shf_cursor[pick] = 13'((x + w) & 32'h1fff);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    // mostly small rectangles and heights that match a stored shelf,
    // the rest larger, up to the whole field range
    task automatic draw_request(output logic [11:0] w, output logic [11:0] h);
        int unsigned sel, rh, lo, hi;
        sel = $urandom_range(99);
        w = 12'($urandom_range(48));
        h = 12'($urandom_range(40, 1));
        if (sel < 25 && shf_count != 0) begin
            rh = 32'(shf_height[$urandom_range(shf_count - 1)]);
            lo = (7 * rh + 9) / 10;
            hi = (rh > 4095) ? 4095 : rh;
            if (rh != 0 && lo <= hi)
                h = 12'($urandom_range(hi, lo));
            w = 12'($urandom_range(300));
        end else if (sel < 70) begin
            // small defaults above
        end else if (sel < 85) begin
            w = 12'($urandom_range(600));
            h = 12'($urandom_range(200, 1));
        end else if (sel < 92) begin
            w = 12'($urandom_range(4095));
            h = 12'($urandom_range(1200, 1));
        end else begin
            w = 12'($urandom_range(4095));
            h = 12'($urandom_range(4095));
        end
    endtask

    // offer one item and return at the edge where it is accepted
    task automatic offer_request(input logic [11:0] w, input logic [11:0] h);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {h, w};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // receiver: random stalls, or a counted hold-off when one is asked for
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ask_count != hold_seen_count) begin
            hold_seen_count <= hold_ask_count;
            hold_left       <= HOLD_CYCLES;
            m_tready        <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // result checker: values read here are those at the edge
    always @(posedge aclk) begin
        sap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (placement_q.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                want = placement_q.pop_front();
                if (m_tdata[11:0] != want.place_x)
                    report_mismatch($sformatf("place_x %0d, expected %0d",
                        m_tdata[11:0], want.place_x));
                if (m_tdata[23:12] != want.place_y)
                    report_mismatch($sformatf("place_y %0d, expected %0d",
                        m_tdata[23:12], want.place_y));
                if (m_tdata[36:24] != want.atlas_width)
                    report_mismatch($sformatf("atlas_width %0d, expected %0d",
                        m_tdata[36:24], want.atlas_width));
                if (m_tdata[49:37] != want.atlas_height)
                    report_mismatch($sformatf("atlas_height %0d, expected %0d",
                        m_tdata[49:37], want.atlas_height));
                if (m_tuser != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        m_tuser, want.status));
                case (want.status)
                    STATUS_PLACED: placed_count++;
                    STATUS_FULL:   full_count++;
                    default:       size_count++;
                endcase
            end
        end
    end

    // watchdog: ends the run when no item moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles, %0d results pending",
            WATCHDOG_LIMIT, placement_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [11:0] w, h;
        sap_result_t r;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // phase one: light sender gaps, heavy receiver stalls
        snd_idle_pct = 6;
        rcv_idle_pct = 57;
        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_request(DIRECTED[i].w, DIRECTED[i].h);
            r = place_rect(DIRECTED[i].w, DIRECTED[i].h);
            if (DIRECTED[i].typed)
                r = DIRECTED[i].res;
            placement_q.push_back(r);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                // phase two: the other way round
                snd_idle_pct = 57;
                rcv_idle_pct = 6;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                // phase three: no idling, one long hold-off to fill the block
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
                hold_ask_count <= hold_ask_count + 1;
            end
            draw_request(w, h);
            offer_request(w, h);
            placement_q.push_back(place_rect(w, h));
        end
        s_tvalid <= 1'b0;

        while (placement_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests: %0d placed, %0d refused with the table full, %0d over size",
            sent_count, placed_count, full_count, size_count);
        $display("shelves in use %0d, final image %0d x %0d, %0d mismatches",
            shf_count, side_w, side_h, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
